// ===== hdl/dtr_pkg.sv =====
`default_nettype none
package dtr_pkg;

	localparam int NUM_W    = 12;
	localparam int LETTER_W = 7;
	localparam int NUM_SYM  = 13;
	localparam int SYM_W    = 4;
	localparam int UPC_W    = 2;
	localparam int COND_W   = 2;

	localparam logic [NUM_W-1:0] MAX_VALID = 12'd3999;

	// ASCII numeral letters
	localparam logic [LETTER_W-1:0] CH_NONE = 7'h00;
	localparam logic [LETTER_W-1:0] CH_I    = 7'h49;
	localparam logic [LETTER_W-1:0] CH_V    = 7'h56;
	localparam logic [LETTER_W-1:0] CH_X    = 7'h58;
	localparam logic [LETTER_W-1:0] CH_L    = 7'h4C;
	localparam logic [LETTER_W-1:0] CH_C    = 7'h43;
	localparam logic [LETTER_W-1:0] CH_D    = 7'h44;
	localparam logic [LETTER_W-1:0] CH_M    = 7'h4D;

	typedef logic [SYM_W-1:0]    sym_idx_t;
	typedef logic [UPC_W-1:0]    upc_t;
	typedef logic [COND_W-1:0]   cond_t;
	typedef logic [NUM_W-1:0]    num_t;
	typedef logic [LETTER_W-1:0] letter_t;

	// microprogram steps
	localparam upc_t UPC_IDLE  = 2'd0;
	localparam upc_t UPC_EMIT1 = 2'd1;
	localparam upc_t UPC_EMIT2 = 2'd2;

	// jump conditions
	localparam cond_t COND_NEVER    = 2'd0;
	localparam cond_t COND_IN_VALID = 2'd1;
	localparam cond_t COND_PAIR     = 2'd2;
	localparam cond_t COND_ALWAYS   = 2'd3;

	typedef struct packed {
		logic  take_in;
		logic  emit;
		logic  pick_second;
		cond_t cond;
		upc_t  next;
		upc_t  jump;
	} uword_t;

	typedef struct packed {
		logic in_valid;
		logic adv;
		logic pair;
		logic last;
	} dp_status_t;

	function automatic uword_t ucode(upc_t upc);
		uword_t w;
		case (upc)
			UPC_IDLE:  w = '{take_in: 1'b1, emit: 1'b0, pick_second: 1'b0,
					cond: COND_IN_VALID, next: UPC_IDLE, jump: UPC_EMIT1};
			UPC_EMIT1: w = '{take_in: 1'b0, emit: 1'b1, pick_second: 1'b0,
					cond: COND_PAIR, next: UPC_EMIT1, jump: UPC_EMIT2};
			UPC_EMIT2: w = '{take_in: 1'b0, emit: 1'b1, pick_second: 1'b1,
					cond: COND_ALWAYS, next: UPC_EMIT2, jump: UPC_EMIT1};
			default:   w = '{take_in: 1'b0, emit: 1'b0, pick_second: 1'b0,
					cond: COND_ALWAYS, next: UPC_IDLE, jump: UPC_IDLE};
		endcase
		return w;
	endfunction

	function automatic num_t sym_value(sym_idx_t i);
		num_t v;
		case (i)
			4'd0:    v = 12'd1000;
			4'd1:    v = 12'd900;
			4'd2:    v = 12'd500;
			4'd3:    v = 12'd400;
			4'd4:    v = 12'd100;
			4'd5:    v = 12'd90;
			4'd6:    v = 12'd50;
			4'd7:    v = 12'd40;
			4'd8:    v = 12'd10;
			4'd9:    v = 12'd9;
			4'd10:   v = 12'd5;
			4'd11:   v = 12'd4;
			default: v = 12'd1;
		endcase
		return v;
	endfunction

	function automatic letter_t sym_first(sym_idx_t i);
		letter_t c;
		case (i)
			4'd0:    c = CH_M;
			4'd1:    c = CH_C;
			4'd2:    c = CH_D;
			4'd3:    c = CH_C;
			4'd4:    c = CH_C;
			4'd5:    c = CH_X;
			4'd6:    c = CH_L;
			4'd7:    c = CH_X;
			4'd8:    c = CH_X;
			4'd9:    c = CH_I;
			4'd10:   c = CH_V;
			4'd11:   c = CH_I;
			default: c = CH_I;
		endcase
		return c;
	endfunction

	// CH_NONE for single-letter symbols
	function automatic letter_t sym_second(sym_idx_t i);
		letter_t c;
		case (i)
			4'd1:    c = CH_M;
			4'd3:    c = CH_D;
			4'd5:    c = CH_C;
			4'd7:    c = CH_L;
			4'd9:    c = CH_X;
			4'd11:   c = CH_V;
			default: c = CH_NONE;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/dtr_in_if.sv =====
`default_nettype none
interface dtr_in_if;
	logic                      valid;
	logic                      ready;
	logic [dtr_pkg::NUM_W-1:0] number;

	modport source (output valid, output number, input ready);
	modport sink   (input valid, input number, output ready);
endinterface
`default_nettype wire

// ===== hdl/dtr_out_if.sv =====
`default_nettype none
interface dtr_out_if;
	logic                         valid;
	logic                         ready;
	logic [dtr_pkg::LETTER_W-1:0] letter;
	logic                         last;
	logic                         invalid;

	modport source (output valid, output letter, output last, output invalid, input ready);
	modport sink   (input valid, input letter, input last, input invalid, output ready);
endinterface
`default_nettype wire

// ===== hdl/dtr_seq.sv =====
`default_nettype none
// Microcode sequencer: step counter, control ROM, conditional jump.
module dtr_seq (
	input  wire                 clk,
	input  wire                 arst_n,
	input  dtr_pkg::dp_status_t status,
	output dtr_pkg::uword_t     uword
);

	dtr_pkg::upc_t upc_q;
	dtr_pkg::upc_t upc_d;
	logic          cond_true;

	assign uword = dtr_pkg::ucode(upc_q);

	always_comb begin
		case (uword.cond)
			dtr_pkg::COND_IN_VALID: cond_true = status.in_valid;
			dtr_pkg::COND_PAIR:     cond_true = status.pair;
			dtr_pkg::COND_ALWAYS:   cond_true = 1'b1;
			default:                cond_true = 1'b0;
		endcase
	end

	always_comb begin
		if (uword.emit && !status.adv) begin
			upc_d = upc_q;                 // output stalled
		end else if (uword.emit && status.last) begin
			upc_d = dtr_pkg::UPC_IDLE;     // run finished
		end else if (cond_true) begin
			upc_d = uword.jump;
		end else begin
			upc_d = uword.next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= dtr_pkg::UPC_IDLE;
		end else begin
			upc_q <= upc_d;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/decimal_to_roman.sv =====
`default_nettype none
// Channel  Dir  Payload                        Transfer
// din      in   number[11:0]                   valid & ready
// dout     out  letter[6:0], last, invalid     valid & ready
//
// A number is taken in the idle step, then one letter enters the output
// register per cycle while dout is not stalled.
// Zero or values above 3999 give a single invalid result.
// The sequencer emits one letter per emit microstep.
// din.ready is high only while the sequencer sits in its idle step; the next
// number may be taken while the final letter still waits in dout.
// A stalled dout holds the sequencer on its current emit step. Reset clears the
// step counter and the output valid flag.
module decimal_to_roman (
	input  wire       clk,
	input  wire       arst_n,
	dtr_in_if.sink    din,
	dtr_out_if.source dout
);

	dtr_pkg::uword_t     uw;
	dtr_pkg::dp_status_t st;

	// datapath registers
	dtr_pkg::num_t     rest_q;     // remainder still to convert
	dtr_pkg::sym_idx_t sym_q;      // symbol whose second letter is pending
	logic              ovalid_q;
	dtr_pkg::letter_t  letter_q;
	logic              last_q;
	logic              invalid_q;

	dtr_pkg::sym_idx_t match;
	dtr_pkg::num_t     diff;
	logic              bad;
	logic              pair;
	logic              adv;
	logic              accept;
	logic              step_fire;
	dtr_pkg::letter_t  letter_d;
	logic              last_d;

	dtr_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (st),
		.uword  (uw)
	);

	assign din.ready = uw.take_in;
	assign accept    = din.valid && din.ready;
	assign adv       = !ovalid_q || dout.ready;
	assign step_fire = uw.emit && adv;

	// greedy pick: largest table value not above the remainder
	always_comb begin
		match = dtr_pkg::sym_idx_t'(dtr_pkg::NUM_SYM - 1);
		for (int i = dtr_pkg::NUM_SYM - 1; i >= 0; i--) begin
			if (rest_q >= dtr_pkg::sym_value(dtr_pkg::sym_idx_t'(i))) begin
				match = dtr_pkg::sym_idx_t'(i);
			end
		end
	end

	assign bad  = (rest_q == '0) || (rest_q > dtr_pkg::MAX_VALID);
	assign diff = rest_q - dtr_pkg::sym_value(match);
	assign pair = !bad && (dtr_pkg::sym_second(match) != dtr_pkg::CH_NONE);

	// letter and end-of-run flag for the current microstep
	always_comb begin
		if (uw.pick_second) begin
			letter_d = dtr_pkg::sym_second(sym_q);
			last_d   = (rest_q == '0);
		end else if (bad) begin
			letter_d = dtr_pkg::CH_NONE;
			last_d   = 1'b1;
		end else begin
			letter_d = dtr_pkg::sym_first(match);
			last_d   = (diff == '0) && !pair;
		end
	end

	assign st = '{in_valid: din.valid, adv: adv, pair: pair, last: last_d};

	always_ff @(posedge clk) begin
		if (accept) begin
			rest_q <= din.number;
		end else if (step_fire && !uw.pick_second && !bad) begin
			rest_q <= diff;
			sym_q  <= match;
		end
		if (step_fire) begin
			letter_q  <= letter_d;
			last_q    <= last_d;
			invalid_q <= bad && !uw.pick_second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (step_fire) begin
			ovalid_q <= 1'b1;
		end else if (dout.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	assign dout.valid   = ovalid_q;
	assign dout.letter  = letter_q;
	assign dout.last    = last_q;
	assign dout.invalid = invalid_q;

endmodule
`default_nettype wire
